// ----- hw/rtl/ppleb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ppleb_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LINE_LEN_W      = 6;
  localparam int unsigned REQ_W           = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned LINE_BYTES_DEF  = 64;

  localparam logic [BYTE_W-1:0] TERM_FIRST_RST  = 8'd13;
  localparam logic [BYTE_W-1:0] TERM_SECOND_RST = 8'd10;

  typedef enum logic [REQ_W-1:0] {
    REQ_RX       = 2'd0,
    REQ_TX_EMPTY = 2'd1,
    REQ_TX_DONE  = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_IRQ_ENABLE = 2'd0,
    CFG_TX_IRQ_START  = 2'd1,
    CFG_TERM_FIRST    = 2'd2,
    CFG_TERM_SECOND   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                  tx_valid;
    logic                  line_done;
    logic [LINE_LEN_W-1:0] line_length;
    logic                  line_buffer;
    logic                  tx_armed;
    logic                  tc_armed;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ppleb_line_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppleb_line_ram #(
  parameter int unsigned DEPTH  = 2 * ppleb_pkg::LINE_BYTES_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [ADDR_W-1:0]             waddr_i,
  input  wire logic [ppleb_pkg::BYTE_W-1:0]  wdata_i,
  input  wire logic                          re_i,
  input  wire logic [ADDR_W-1:0]             raddr_i,
  output      logic [ppleb_pkg::BYTE_W-1:0]  rdata_o
);
  import ppleb_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ping_pong_line_echo_buffer.sv -----
// pipeline: two register stages; a transferred item's result goes to p_res_q, then o_res_q
// throughput: one item per cycle unless the output stalls; the line store is read at the input
// transfer and its registered byte joins the result as it moves into the output register
// reset: asynchronous active low; both fill counts, buffer select and send
// index clear, send and complete handling disarmed, terminators 13 and 10
// line store contents are undefined after reset and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module ping_pong_line_echo_buffer #(
  parameter int unsigned LINE_BYTES = ppleb_pkg::LINE_BYTES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [ppleb_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [ppleb_pkg::BYTE_W-1:0]      rx_byte_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic                              tx_valid_o,
  output      logic [ppleb_pkg::BYTE_W-1:0]      tx_byte_o,
  output      logic                              line_done_o,
  output      logic [ppleb_pkg::LINE_LEN_W-1:0]  line_length_o,
  output      logic                              line_buffer_o,
  output      logic                              tx_armed_o,
  output      logic                              tc_armed_o,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [ppleb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [ppleb_pkg::BYTE_W-1:0]      cfg_data_i
);
  import ppleb_pkg::*;

  localparam int unsigned CNT_W  = $clog2(LINE_BYTES);
  localparam int unsigned DEPTH  = 2 * LINE_BYTES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(LINE_BYTES - 1);
  localparam logic [ADDR_W-1:0] BUF1_BASE = ADDR_W'(LINE_BYTES);

  // configuration
  logic              rx_en_q;
  logic [BYTE_W-1:0] term_first_q, term_second_q;
  logic              cfg_we;

  // line state
  logic [CNT_W-1:0] fill_q [2];
  logic [CNT_W-1:0] fill_d [2];
  logic             sel_q, sel_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             send_armed_q, send_armed_d;
  logic             tc_armed_q, tc_armed_d;

  // pipeline
  logic              accept, p_move;
  logic              p_valid_q;
  result_t           p_res_q, res;
  logic              o_valid_q;
  result_t           o_res_q;
  logic [BYTE_W-1:0] o_byte_q;

  // store access
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic             txb;
  logic [CNT_W-1:0] fill_cur, fill_tx;
  logic             is_term;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  assign p_move     = p_valid_q && (!o_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !p_move;
  assign accept     = in_valid_i && !in_stall_o;

  assign txb      = ~sel_q;
  assign fill_cur = fill_q[sel_q];
  assign fill_tx  = fill_q[txb];
  assign is_term  = (rx_byte_i == term_first_q) || (rx_byte_i == term_second_q);

  assign ram_waddr = sel_q ? (BUF1_BASE + ADDR_W'(fill_cur)) : ADDR_W'(fill_cur);
  assign ram_raddr = txb ? (BUF1_BASE + ADDR_W'(idx_q)) : ADDR_W'(idx_q);

  always_comb begin
    fill_d[0]    = fill_q[0];
    fill_d[1]    = fill_q[1];
    sel_d        = sel_q;
    idx_d        = idx_q;
    send_armed_d = send_armed_q;
    tc_armed_d   = tc_armed_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    res          = '0;

    if (accept) begin
      case (req_e'(req_type_i))
        REQ_RX: begin
          if (rx_en_q) begin
            if (is_term) begin
              res.line_done   = 1'b1;
              res.line_length = LINE_LEN_W'(fill_cur);
              res.line_buffer = sel_q;
              sel_d           = txb;
              fill_d[txb]     = '0;
              idx_d           = '0;
              if (tc_armed_q) begin
                send_armed_d = 1'b1;
              end
            end else if (fill_cur < FILL_MAX) begin
              ram_we        = 1'b1;
              fill_d[sel_q] = fill_cur + CNT_W'(1);
            end
          end
        end
        REQ_TX_EMPTY: begin
          if (send_armed_q) begin
            if (idx_q < fill_tx) begin
              ram_re       = 1'b1;
              res.tx_valid = 1'b1;
              idx_d        = idx_q + CNT_W'(1);
            end else begin
              send_armed_d = 1'b0;
              tc_armed_d   = 1'b1;
              fill_d[txb]  = '0;
              idx_d        = '0;
            end
          end
        end
        REQ_TX_DONE: begin
          tc_armed_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // the user loads it only while idle, never together with a transfer; the block does not enforce this
    if (cfg_we && (cfg_idx_e'(cfg_index_i) == CFG_TX_IRQ_START)) begin
      send_armed_d = cfg_data_i[0];
    end

    res.tx_armed = send_armed_d;
    res.tc_armed = tc_armed_d;
  end

  // start value goes straight into send handling above
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_en_q       <= 1'b0;
      term_first_q  <= TERM_FIRST_RST;
      term_second_q <= TERM_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_RX_IRQ_ENABLE: rx_en_q       <= cfg_data_i[0];
        CFG_TERM_FIRST:    term_first_q  <= cfg_data_i;
        CFG_TERM_SECOND:   term_second_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q[0]    <= '0;
      fill_q[1]    <= '0;
      sel_q        <= 1'b0;
      idx_q        <= '0;
      send_armed_q <= 1'b0;
      tc_armed_q   <= 1'b0;
    end else begin
      fill_q[0]    <= fill_d[0];
      fill_q[1]    <= fill_d[1];
      sel_q        <= sel_d;
      idx_q        <= idx_d;
      send_armed_q <= send_armed_d;
      tc_armed_q   <= tc_armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_q <= 1'b1;
      end else if (p_move) begin
        p_valid_q <= 1'b0;
      end
      if (p_move) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_res_q <= res;
    end
    if (p_move) begin
      o_res_q  <= p_res_q;
      o_byte_q <= p_res_q.tx_valid ? ram_rdata : '0;
    end
  end

  ppleb_line_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = o_valid_q;
  assign tx_valid_o    = o_res_q.tx_valid;
  assign tx_byte_o     = o_byte_q;
  assign line_done_o   = o_res_q.line_done;
  assign line_length_o = o_res_q.line_length;
  assign line_buffer_o = o_res_q.line_buffer;
  assign tx_armed_o    = o_res_q.tx_armed;
  assign tc_armed_o    = o_res_q.tc_armed;

endmodule

`default_nettype wire

// ----- hw/rtl/ppleb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppleb_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic                              tx_valid_o,
  input wire logic [ppleb_pkg::BYTE_W-1:0]      tx_byte_o,
  input wire logic                              line_done_o,
  input wire logic [ppleb_pkg::LINE_LEN_W-1:0]  line_length_o,
  input wire logic                              line_buffer_o,
  input wire logic                              tx_armed_o
);
  import ppleb_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no byte sent means a zero byte
  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == '0)
    else $error("tx byte not zero without send");

  // a line end and a sent byte never come from one event
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> !tx_valid_o)
    else $error("line end and send in one result");

  // line fields stay zero without a line end
  a_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_done_o |-> line_length_o == '0 && !line_buffer_o)
    else $error("line fields set without line end");

  // a sent byte leaves send handling armed
  a_send_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_valid_o |-> tx_armed_o)
    else $error("byte sent while send disarmed");

endmodule

bind ping_pong_line_echo_buffer ppleb_checker u_ppleb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tx_valid_o    (tx_valid_o),
  .tx_byte_o     (tx_byte_o),
  .line_done_o   (line_done_o),
  .line_length_o (line_length_o),
  .line_buffer_o (line_buffer_o),
  .tx_armed_o    (tx_armed_o)
);

`default_nettype wire
